// File: sv/shi_pkg.sv
// shared types, codes and defaults for the sorted history interpolator
// no dependencies; imported by the top module and shi_ram, and used by the bench
package shi_pkg;

	localparam int DEPTH_DEF = 1024;

	// register indexes of the write port
	localparam logic [1:0] REG_KEEP_LIMIT     = 2'd0;
	localparam logic [1:0] REG_USE_DEFAULT    = 2'd1;
	localparam logic [1:0] REG_FALLBACK_VALUE = 2'd2;

	localparam logic [10:0] KEEP_LIMIT_RST = 11'd1024;

	// request kinds
	localparam logic KIND_PUSH  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// answer status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BEFORE = 2'd1;
	localparam logic [1:0] ST_AFTER  = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic               kind;
		logic        [31:0] sample_time;
		logic signed [31:0] sample_value;
		logic               interpolate;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic        [1:0]  status;
	} answer_t;

	// stored entry: time above value
	typedef struct packed {
		logic [31:0] etime;
		logic [31:0] evalue;
	} entry_t;

endpackage

// File: sv/shi_stream_if.sv
// valid/ready channel carrying one payload of a given type
// depends on nothing; payload types come from shi_pkg
interface shi_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/sorted_history_interpolator.sv
// sorted history interpolator: ring-buffer store of sorted (time, value) pairs
// depends on shi_pkg, shi_stream_if, shi_ram and shi_div
//
//  channel   dir  payload                                          per request
//  item      in   kind, sample_time, sample_value, interpolate     push or query
//  result    out  result_value, status                             one per query
//  wr_*      in   keep_limit / use_default / fallback_value        register write
//
// a request runs a binary search of ceil(log2(entries+1)) steps, each a read
// state and a compare state, then the probe states; a query that interpolates
// adds the multiply and the 32-step divider; a push also moves each entry up
// behind the insertion point. the single memory port pair orders these steps.
// reset empties the store at once (entry count and ring head only).
// while an answer waits, the next query holds in its answer state and blocks input.
module sorted_history_interpolator #(
	parameter int DEPTH = shi_pkg::DEPTH_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	shi_stream_if.sink              item,
	shi_stream_if.source            result,
	input logic                     wr_en,
	input logic [1:0]               wr_index,
	input logic [31:0]              wr_data
);
	import shi_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > 11) ? CW : 11;

	typedef enum logic [16:0] {
		S_IDLE      = 17'h00001,
		S_SRCH_RD   = 17'h00002,
		S_SRCH_CMP  = 17'h00004,
		S_PROBE_RD  = 17'h00008,
		S_PROBE_CHK = 17'h00010,
		S_PREV_CHK  = 17'h00020,
		S_LAST_CHK  = 17'h00040,
		S_MUL       = 17'h00080,
		S_DSTART    = 17'h00100,
		S_DIV       = 17'h00200,
		S_FIX       = 17'h00400,
		S_EMIT      = 17'h00800,
		S_PUSH_PREP = 17'h01000,
		S_SHIFT_RD  = 17'h02000,
		S_SHIFT_WR  = 17'h04000,
		S_INS       = 17'h08000,
		S_TRIM      = 17'h10000
	} state_t;

	state_t state_q;

	// configuration
	logic [10:0] keep_limit_q;
	logic        use_default_q;
	logic [31:0] fallback_q;

	// store bookkeeping
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] lo_q;
	logic [CW-1:0] hi_q;
	logic [CW-1:0] j_q;

	// request and arithmetic registers
	item_t       req_q;
	logic [31:0] t1_q;
	logic [31:0] v1_q;
	logic [31:0] v0_q;
	logic [31:0] dt_q;
	logic [31:0] span_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [63:0] prod_q;
	answer_t     pend_q;
	answer_t     res_q;
	logic        res_valid_q;

	// memory and divider hookup
	logic          we;
	logic [CW-1:0] wr_log;
	entry_t        wdata;
	logic [CW-1:0] rd_log;
	entry_t        rdata;
	logic          div_start;
	logic          div_done;
	logic [31:0]   quot;

	logic [CW-1:0] mid;
	logic [CW-1:0] lim;
	logic [32:0]   dv;
	logic [32:0]   sum;

	// logical slot to ring address
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [CW-1:0] l);
		logic [AW:0] s;
		s = {1'b0, head} + (AW+1)'(l);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign lim = (LW'(keep_limit_q) > LW'(DEPTH)) ? CW'(DEPTH) : CW'(keep_limit_q);
	assign dv  = {rdata.evalue[31], rdata.evalue} - {v1_q[31], v1_q};

	// memory address and write selection
	always_comb begin
		rd_log = '0;
		wr_log = j_q;
		we     = 1'b0;
		wdata  = rdata;
		case (state_q)
			S_SRCH_RD:   rd_log = mid;
			S_PROBE_RD:  rd_log = (lo_q < count_q) ? lo_q : count_q - CW'(1);
			S_PROBE_CHK: rd_log = lo_q - CW'(1);
			S_SHIFT_RD:  rd_log = j_q - CW'(1);
			S_SHIFT_WR:  we = 1'b1;
			S_INS: begin
				we     = 1'b1;
				wr_log = lo_q;
				wdata  = {req_q.sample_time, req_q.sample_value};
			end
			default: ;
		endcase
	end

	shi_ram #(.DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (phys(head_q, wr_log)),
		.wdata (wdata),
		.raddr (phys(head_q, rd_log)),
		.rdata (rdata)
	);

	assign div_start = (state_q == S_DSTART);

	shi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_hi (prod_q[63:32]),
		.num_lo (prod_q[31:0]),
		.den    (span_q),
		.done   (div_done),
		.quot   (quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_limit_q  <= KEEP_LIMIT_RST;
			use_default_q <= 1'b0;
			fallback_q    <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_KEEP_LIMIT:     keep_limit_q  <= wr_data[10:0];
				REG_USE_DEFAULT:    use_default_q <= wr_data[0];
				REG_FALLBACK_VALUE: fallback_q    <= wr_data;
				default: ;
			endcase
		end
	end

	assign item.ready = (state_q == S_IDLE);
	assign sum = {v0_q[31], v0_q} + (neg_q ? -{1'b0, quot} : {1'b0, quot});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
			t1_q        <= '0;
			v1_q        <= '0;
			v0_q        <= '0;
			dt_q        <= '0;
			span_q      <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			pend_q      <= '0;
		end else begin
			// answer register handshake
			if (state_q == S_EMIT && (!res_valid_q || result.ready)) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						lo_q <= '0;
						hi_q <= count_q;
						if (item.data.kind == KIND_QUERY && count_q == '0) begin
							pend_q.status <= (item.data.interpolate && use_default_q)
								? ST_OK : ST_EMPTY;
							pend_q.result_value <= (item.data.interpolate && use_default_q)
								? fallback_q : '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					state_q <= (lo_q < hi_q) ? S_SRCH_CMP : S_PROBE_RD;
				end
				S_SRCH_CMP: begin
					if (rdata.etime < req_q.sample_time) begin
						lo_q <= mid + CW'(1);
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH_RD;
				end
				S_PROBE_RD: begin
					if (lo_q < count_q) begin
						state_q <= S_PROBE_CHK;
					end else if (req_q.kind == KIND_PUSH) begin
						state_q <= S_PUSH_PREP;
					end else if (!req_q.interpolate) begin
						state_q <= S_LAST_CHK;
					end else begin
						pend_q.status       <= use_default_q ? ST_OK : ST_AFTER;
						pend_q.result_value <= use_default_q ? fallback_q : '0;
						state_q             <= S_EMIT;
					end
				end
				S_PROBE_CHK: begin
					t1_q <= rdata.etime;
					v1_q <= rdata.evalue;
					if (req_q.kind == KIND_PUSH) begin
						state_q <= (rdata.etime == req_q.sample_time) ? S_TRIM : S_PUSH_PREP;
					end else if (rdata.etime == req_q.sample_time) begin
						pend_q.status       <= ST_OK;
						pend_q.result_value <= rdata.evalue;
						state_q             <= S_EMIT;
					end else if (lo_q == '0) begin
						pend_q.status       <= use_default_q ? ST_OK : ST_BEFORE;
						pend_q.result_value <= use_default_q ? fallback_q : '0;
						state_q             <= S_EMIT;
					end else begin
						state_q <= S_PREV_CHK;
					end
				end
				S_PREV_CHK: begin
					v0_q   <= rdata.evalue;
					dt_q   <= req_q.sample_time - rdata.etime;
					span_q <= t1_q - rdata.etime;
					neg_q  <= ~dv[32];
					mag_q  <= dv[32] ? 32'(-dv) : dv[31:0];
					if (req_q.interpolate) begin
						state_q <= S_MUL;
					end else begin
						pend_q.status       <= ST_OK;
						pend_q.result_value <= rdata.evalue;
						state_q             <= S_EMIT;
					end
				end
				S_LAST_CHK: begin
					pend_q.status       <= ST_OK;
					pend_q.result_value <= rdata.evalue;
					state_q             <= S_EMIT;
				end
				S_MUL: begin
					state_q <= S_DSTART;
				end
				S_DSTART: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					pend_q.status       <= ST_OK;
					pend_q.result_value <= sum[31:0];
					state_q             <= S_EMIT;
				end
				S_EMIT: begin
					if (!res_valid_q || result.ready) begin
						state_q <= S_IDLE;
					end
				end
				S_PUSH_PREP: begin
					if (count_q >= CW'(DEPTH)) begin
						if (lo_q == '0) begin
							state_q <= S_TRIM;
						end else begin
							head_q  <= phys(head_q, CW'(1));
							count_q <= count_q - CW'(1);
							lo_q    <= lo_q - CW'(1);
							j_q     <= count_q - CW'(1);
							state_q <= S_SHIFT_RD;
						end
					end else begin
						j_q     <= count_q;
						state_q <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= (j_q > lo_q) ? S_SHIFT_WR : S_INS;
				end
				S_SHIFT_WR: begin
					j_q     <= j_q - CW'(1);
					state_q <= S_SHIFT_RD;
				end
				S_INS: begin
					count_q <= count_q + CW'(1);
					state_q <= S_TRIM;
				end
				S_TRIM: begin
					if (count_q > lim) begin
						head_q  <= phys(head_q, count_q - lim);
						count_q <= lim;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture, product and answer payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			req_q <= item.data;
		end
		if (state_q == S_MUL) begin
			prod_q <= 64'(dt_q) * 64'(mag_q);
		end
		if (state_q == S_EMIT && (!res_valid_q || result.ready)) begin
			res_q <= pend_q;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

`ifndef SYNTHESIS
	// the store never holds more entries than it has slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// the divider only finishes while the sequencer waits for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	// after the trim the store is within the keep limit
	a_trim_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TRIM |=> count_q <= lim)
		else $error("trim left too many entries");
`endif
endmodule

// File: sv/shi_ram.sv
// single-port-write, single-port-read entry memory with registered read data
// depends on shi_pkg for the entry type
module shi_ram #(
	parameter int DEPTH = shi_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  shi_pkg::entry_t          wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output shi_pkg::entry_t          rdata
);
	import shi_pkg::*;

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// File: sv/shi_div.sv
// iterative unsigned divider, one quotient bit per cycle
// depends on nothing; expects num_hi below den so the quotient fits 32 bits
module shi_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num_hi,
	input  logic [31:0] num_lo,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quot
);
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;
	logic        fits;

	// one restoring step
	assign trial = {rem_q, quo_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num_hi;
			quo_q <= num_lo;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
endmodule

// File: bench/shi_history_board.sv
// history board: predicts answers of the sorted history interpolator and checks them
// depends on shi_pkg; instantiated by the tb module
`timescale 1ns / 100ps

class shi_history_board;
	localparam int CAP = shi_pkg::DEPTH_DEF;

	bit [31:0] times[$];
	bit [31:0] values[$];
	bit [10:0] keep_limit;
	bit        use_default;
	bit [31:0] fallback_value;
	shi_pkg::answer_t pending[$];
	int errors;

	function new();
		keep_limit = shi_pkg::KEEP_LIMIT_RST;
		use_default = 0;
		fallback_value = 0;
		errors = 0;
	endfunction

	function void set_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			shi_pkg::REG_KEEP_LIMIT: keep_limit = data[10:0];
			shi_pkg::REG_USE_DEFAULT: use_default = data[0];
			shi_pkg::REG_FALLBACK_VALUE: fallback_value = data;
			default: ;
		endcase
	endfunction

	// first slot whose time is not below t
	function int lower_slot(bit [31:0] t);
		int lo, hi, mid;
		lo = 0;
		hi = times.size();
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (times[mid] < t) lo = mid + 1; else hi = mid;
		end
		return lo;
	endfunction

	// note an accepted request; queries add one expected answer
	function void note_request(shi_pkg::item_t it);
		int p, lim;
		shi_pkg::answer_t a;
		longint v0, v1, dv, q;
		longint unsigned dt, span, mag;
		lim = (keep_limit > CAP) ? CAP : keep_limit;
		if (it.kind == shi_pkg::KIND_PUSH) begin
			p = lower_slot(it.sample_time);
			if (!(p < times.size() && times[p] == it.sample_time)) begin
				if (times.size() >= CAP && p == 0) begin
				end else begin
					if (times.size() >= CAP) begin
						void'(times.pop_front());
						void'(values.pop_front());
						p--;
					end
					times.insert(p, it.sample_time);
					values.insert(p, it.sample_value);
				end
			end
			while (times.size() > lim) begin
				void'(times.pop_front());
				void'(values.pop_front());
			end
			return;
		end
		a.result_value = 0;
		a.status = shi_pkg::ST_OK;
		if (times.size() == 0) begin
			if (it.interpolate && use_default) a.result_value = fallback_value;
			else a.status = shi_pkg::ST_EMPTY;
		end else begin
			p = lower_slot(it.sample_time);
			if (p >= times.size()) begin
				if (!it.interpolate) a.result_value = values[$];
				else if (use_default) a.result_value = fallback_value;
				else a.status = shi_pkg::ST_AFTER;
			end else if (times[p] == it.sample_time) begin
				a.result_value = values[p];
			end else if (p == 0) begin
				if (use_default) a.result_value = fallback_value;
				else a.status = shi_pkg::ST_BEFORE;
			end else if (!it.interpolate) begin
				a.result_value = values[p-1];
			end else begin
				v0 = longint'($signed(values[p-1]));
				v1 = longint'($signed(values[p]));
				dt = 64'(it.sample_time - times[p-1]);
				span = 64'(times[p] - times[p-1]);
				dv = v1 - v0;
				mag = (dv < 0) ? -dv : dv;
				q = (dt * mag) / span;
				a.result_value = 32'((dv < 0) ? v0 - q : v0 + q);
			end
		end
		pending.push_back(a);
	endfunction

	// compare one answer with the oldest expectation
	function void check_answer(shi_pkg::answer_t got);
		shi_pkg::answer_t exp_a;
		if (pending.size() == 0) begin
			$error("unexpected answer value %0d status %0d", got.result_value, got.status);
			errors++;
			return;
		end
		exp_a = pending.pop_front();
		if (got.result_value !== exp_a.result_value) begin
			$error("result_value expected %0d actual %0d", exp_a.result_value,
				got.result_value);
			errors++;
		end
		if (got.status !== exp_a.status) begin
			$error("status expected %0d actual %0d", exp_a.status, got.status);
			errors++;
		end
	endfunction
endclass

// File: bench/tb.sv
// testbench top for the sorted history interpolator: directed and random requests
// depends on shi_pkg, shi_stream_if, shi_history_board and the block's RTL
`timescale 1ns / 100ps

module tb;
	import shi_pkg::*;

	localparam int IDLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [1:0] wr_index;
	logic [31:0] wr_data;

	shi_stream_if #(.T(item_t)) item_ch ();
	shi_stream_if #(.T(answer_t)) result_ch ();

	sorted_history_interpolator DUT (
		.clk(clk), .arst_n(arst_n),
		.item(item_ch.sink), .result(result_ch.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	shi_history_board board;
	int idle_cycles;
	bit stall_mode;
	bit long_hold;
	bit [31:0] base_t;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern and one long hold-off
	always @(negedge clk) begin
		if (long_hold) result_ch.ready <= 0;
		else if (!stall_mode) result_ch.ready <= 1;
		else result_ch.ready <= ($urandom_range(0, 3) != 0);
	end

	// answer checking and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) board.check_answer(result_ch.data);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("sorted_history_interpolator regression: fail");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		wr_en <= 1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 0;
		board.set_reg(idx, data);
	endtask

	// offer one request and hold it until accepted
	task automatic send(bit k, bit [31:0] t, bit [31:0] v, bit lin);
		item_t it;
		it.kind = k;
		it.sample_time = t;
		it.sample_value = v;
		it.interpolate = lin;
		item_ch.data <= it;
		item_ch.valid <= 1;
		do @(posedge clk); while (!item_ch.ready);
		board.note_request(it);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		item_ch.valid <= 0;
		repeat (n) @(negedge clk);
	endtask

	// wait for every answer and for the block to go idle
	task automatic drain();
		item_ch.valid <= 0;
		@(negedge clk);
		while (board.pending.size() != 0 || !item_ch.ready) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	// bursts of pushes and queries near the stored times
	task automatic random_run(int count, int tspan);
		int burst;
		bit k;
		bit [31:0] t;
		burst = $urandom_range(1, 12);
		for (int i = 0; i < count; i++) begin
			k = ($urandom_range(0, 99) < 45);
			case ($urandom_range(0, 9))
				0: t = $urandom;
				1: t = base_t + $urandom_range(0, 3);
				default: t = base_t + $urandom_range(0, tspan);
			endcase
			send(k, t, $urandom, $urandom_range(0, 1));
			if (--burst == 0) begin
				burst = $urandom_range(1, 12);
				if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 40));
			end
		end
	endtask

	initial begin
		board = new();
		arst_n = 0;
		wr_en = 0;
		wr_index = REG_KEEP_LIMIT;
		wr_data = 0;
		item_ch.valid = 0;
		item_ch.data = '0;
		result_ch.ready = 0;
		stall_mode = 0;
		long_hold = 0;
		idle_cycles = 0;
		base_t = 32'h0000_1000;
		repeat (4) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: empty store, extremes, the special answer cases
		send(KIND_QUERY, 32'd5, 0, 0);
		send(KIND_QUERY, 32'd5, 0, 1);
		send(KIND_PUSH, 32'd100, 32'sd1000, 0);
		send(KIND_PUSH, 32'd300, -32'sd1000, 0);
		send(KIND_PUSH, 32'd100, 32'd7, 0);
		send(KIND_PUSH, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
		send(KIND_PUSH, 32'd0, 32'h8000_0000, 0);
		send(KIND_PUSH, 32'hFFFF_FFF0, 32'h8000_0000, 0);
		send(KIND_QUERY, 32'd100, 0, 1);
		send(KIND_QUERY, 32'd150, 0, 1);
		send(KIND_QUERY, 32'd150, 0, 0);
		send(KIND_QUERY, 32'hFFFF_FFF8, 32'hFFFF_FFFF, 1);
		send(KIND_QUERY, 32'd50, 0, 1);
		send(KIND_QUERY, 32'hFFFF_FFFF, 0, 0);
		drain();
		write_reg(REG_KEEP_LIMIT, 32'd2);
		send(KIND_PUSH, 32'd10, 32'd1, 0);
		send(KIND_QUERY, 32'd0, 0, 0);
		send(KIND_QUERY, 32'd400, 0, 1);
		send(KIND_QUERY, 32'd400, 0, 0);
		drain();
		write_reg(REG_USE_DEFAULT, 32'd1);
		write_reg(REG_FALLBACK_VALUE, 32'h8000_0000);
		send(KIND_QUERY, 32'd1, 0, 0);
		send(KIND_QUERY, 32'hFFFF_FFFF, 0, 1);
		drain();
		write_reg(REG_KEEP_LIMIT, 32'd0);
		send(KIND_PUSH, 32'd10, 32'd1, 0);
		send(KIND_QUERY, 32'd10, 0, 1);
		send(KIND_QUERY, 32'd10, 0, 0);
		drain();

		// random phases across register settings
		stall_mode = 1;
		write_reg(REG_KEEP_LIMIT, 32'd8);
		write_reg(REG_USE_DEFAULT, 32'd0);
		random_run(200, 64);
		drain();
		write_reg(REG_KEEP_LIMIT, 32'd1);
		write_reg(REG_USE_DEFAULT, 32'd1);
		write_reg(REG_FALLBACK_VALUE, 32'h7FFF_FFFF);
		random_run(100, 16);
		drain();
		write_reg(REG_KEEP_LIMIT, 32'd2047);
		write_reg(REG_FALLBACK_VALUE, $urandom);
		base_t = $urandom;
		fork
			begin
				long_hold = 1;
				repeat (3000) @(negedge clk);
				long_hold = 0;
			end
			random_run(200, 4096);
		join
		drain();
		stall_mode = 0;
		write_reg(REG_KEEP_LIMIT, 32'd1024);
		write_reg(REG_USE_DEFAULT, 32'd0);
		random_run(150, 100000);
		drain();
		stall_mode = 1;
		write_reg(REG_KEEP_LIMIT, 32'd30);
		random_run(200, 256);
		drain();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("sorted_history_interpolator regression: pass");
		else
			$display("sorted_history_interpolator regression: fail");
		$finish;
	end
endmodule
